### hdl/r2bpp_pkg.sv
// shared types and constants for the rgb565 four-color 2bpp packer
// no dependencies; the other design files and the bench refer to this package by scoped names
package r2bpp_pkg;

    // store index width covers the largest frame (256 bytes per row, 1024 rows)
    localparam int IDX_W  = 18;
    localparam int CMP_W  = IDX_W + 1;
    localparam int LUMA_W = 18;
    localparam int CFG_W  = 8;

    localparam logic [7:0] CLEAR_BYTE = 8'h55;

    // bt.601 luma weights, sum scaled by 1000
    localparam logic [9:0] LUMA_KR  = 10'd299;
    localparam logic [9:0] LUMA_KG  = 10'd587;
    localparam logic [9:0] LUMA_KB  = 10'd114;
    localparam logic [9:0] LUMA_DIV = 10'd1000;

    localparam logic [CFG_W-1:0] SPREAD_RESET = 8'd32;
    localparam logic [CFG_W-1:0] LUMA_RESET   = 8'd192;

    // register index, taken from paddr[2]
    localparam logic REG_SPREAD = 1'b0;
    localparam logic REG_LUMA   = 1'b1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [1:0] CODE_BLACK  = 2'd0;
    localparam logic [1:0] CODE_WHITE  = 2'd1;
    localparam logic [1:0] CODE_YELLOW = 2'd2;
    localparam logic [1:0] CODE_RED    = 2'd3;

    // classified item handed from front to back
    typedef struct packed {
        logic             is_read;
        logic [1:0]       code;
        logic             err;
        logic [1:0]       lane;
        logic [IDX_W-1:0] idx;
    } t_cmd;

endpackage

### hdl/r2bpp_front.sv
// front end: accepts items, maps the pixel to a color code, checks range, forms the byte index
// depends on r2bpp_pkg
module r2bpp_front #(
    parameter int FRAME_WIDTH  = 160,
    parameter int FRAME_HEIGHT = 296
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_opcode,
    input  logic [15:0]                    i_pixel,
    input  logic [9:0]                     i_x_coord,
    input  logic [9:0]                     i_y_coord,
    input  logic [13:0]                    i_read_address,
    input  logic [r2bpp_pkg::CFG_W-1:0]    i_spread_thr,
    input  logic [r2bpp_pkg::CFG_W-1:0]    i_luma_thr,
    input  logic                           i_hold,
    output logic                           o_cmd_valid,
    output r2bpp_pkg::t_cmd                o_cmd,
    input  logic                           i_cmd_ready
);

    localparam int ROW_BYTES   = (FRAME_WIDTH + 3) / 4;
    localparam int STORE_BYTES = ROW_BYTES * FRAME_HEIGHT;
    localparam int IW = r2bpp_pkg::IDX_W;
    localparam int LW = r2bpp_pkg::LUMA_W;

    logic [7:0] w_r, w_g, w_b, w_hi, w_lo, w_spread;
    logic [7:0] w_ir, w_ig, w_ib;
    logic       w_gray, w_x_ok, w_y_ok, w_addr_ok, w_accept;

    logic          r_s1_valid;
    logic          r_s1_is_read;
    logic          r_s1_gray;
    logic          r_s1_err;
    logic [LW-1:0] r_s1_lr, r_s1_lg, r_s1_lb;
    logic [15:0]   r_s1_sq_r, r_s1_sq_g, r_s1_sq_b;
    logic [15:0]   r_s1_sq_ir, r_s1_sq_ig, r_s1_sq_ib;
    logic [IW-1:0] r_s1_row_base;
    logic [7:0]    r_s1_col;
    logic [1:0]    r_s1_lane;
    logic [13:0]   r_s1_addr;
    logic [LW-1:0] r_luma_limit;

    logic [17:0]   w_dk, w_dw, w_dy, w_dr, w_best1, w_best2;
    logic [1:0]    w_code1, w_code2, w_near, w_code;
    logic [LW-1:0] w_luma_sum;

    // channel widening by top-bit replication
    assign w_r = {i_pixel[15:11], i_pixel[15:13]};
    assign w_g = {i_pixel[10:5], i_pixel[10:9]};
    assign w_b = {i_pixel[4:0], i_pixel[4:2]};

    // 255 minus each channel
    assign w_ir = ~w_r;
    assign w_ig = ~w_g;
    assign w_ib = ~w_b;

    always_comb begin
        w_hi = w_r;
        w_lo = w_r;
        if (w_g > w_hi) w_hi = w_g;
        if (w_b > w_hi) w_hi = w_b;
        if (w_g < w_lo) w_lo = w_g;
        if (w_b < w_lo) w_lo = w_b;
    end

    assign w_spread  = w_hi - w_lo;
    assign w_gray    = w_spread < i_spread_thr;
    assign w_x_ok    = {1'b0, i_x_coord} < 11'(FRAME_WIDTH);
    assign w_y_ok    = {1'b0, i_y_coord} < 11'(FRAME_HEIGHT);
    assign w_addr_ok = r2bpp_pkg::CMP_W'(i_read_address) < r2bpp_pkg::CMP_W'(STORE_BYTES);

    assign o_ready  = !i_hold && (!r_s1_valid || i_cmd_ready);
    assign w_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (i_cmd_ready) begin
            r_s1_valid <= 1'b0;
        end
    end

    // luma compare against thr*1000 replaces the divide by 1000
    always_ff @(posedge i_clk) begin
        r_luma_limit <= LW'(i_luma_thr) * LW'(r2bpp_pkg::LUMA_DIV);
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_is_read  <= (i_opcode == r2bpp_pkg::OP_READ);
            r_s1_gray     <= w_gray;
            r_s1_err      <= (i_opcode == r2bpp_pkg::OP_READ) ? !w_addr_ok
                                                              : !(w_x_ok && w_y_ok);
            r_s1_lr       <= LW'(w_r) * LW'(r2bpp_pkg::LUMA_KR);
            r_s1_lg       <= LW'(w_g) * LW'(r2bpp_pkg::LUMA_KG);
            r_s1_lb       <= LW'(w_b) * LW'(r2bpp_pkg::LUMA_KB);
            r_s1_sq_r     <= 16'(w_r) * 16'(w_r);
            r_s1_sq_g     <= 16'(w_g) * 16'(w_g);
            r_s1_sq_b     <= 16'(w_b) * 16'(w_b);
            r_s1_sq_ir    <= 16'(w_ir) * 16'(w_ir);
            r_s1_sq_ig    <= 16'(w_ig) * 16'(w_ig);
            r_s1_sq_ib    <= 16'(w_ib) * 16'(w_ib);
            r_s1_row_base <= IW'(i_y_coord) * IW'(ROW_BYTES);
            r_s1_col      <= i_x_coord[9:2];
            r_s1_lane     <= i_x_coord[1:0];
            r_s1_addr     <= i_read_address;
        end
    end

    // distances to black, white, yellow, red
    assign w_dk = 18'(r_s1_sq_r) + 18'(r_s1_sq_g) + 18'(r_s1_sq_b);
    assign w_dw = 18'(r_s1_sq_ir) + 18'(r_s1_sq_ig) + 18'(r_s1_sq_ib);
    assign w_dy = 18'(r_s1_sq_ir) + 18'(r_s1_sq_ig) + 18'(r_s1_sq_b);
    assign w_dr = 18'(r_s1_sq_ir) + 18'(r_s1_sq_g) + 18'(r_s1_sq_b);

    // strict less-than keeps the earlier color on a tie
    assign w_best1 = (w_dw < w_dk) ? w_dw : w_dk;
    assign w_code1 = (w_dw < w_dk) ? r2bpp_pkg::CODE_WHITE : r2bpp_pkg::CODE_BLACK;
    assign w_best2 = (w_dy < w_best1) ? w_dy : w_best1;
    assign w_code2 = (w_dy < w_best1) ? r2bpp_pkg::CODE_YELLOW : w_code1;
    assign w_near  = (w_dr < w_best2) ? r2bpp_pkg::CODE_RED : w_code2;

    assign w_luma_sum = r_s1_lr + r_s1_lg + r_s1_lb;

    always_comb begin
        if (r_s1_is_read) begin
            w_code = r2bpp_pkg::CODE_BLACK;
        end else if (r_s1_gray) begin
            w_code = (w_luma_sum < r_luma_limit) ? r2bpp_pkg::CODE_BLACK
                                                 : r2bpp_pkg::CODE_WHITE;
        end else begin
            w_code = w_near;
        end
    end

    assign o_cmd_valid  = r_s1_valid;
    assign o_cmd.is_read = r_s1_is_read;
    assign o_cmd.code    = w_code;
    assign o_cmd.err     = r_s1_err;
    assign o_cmd.lane    = r_s1_lane;
    assign o_cmd.idx     = r_s1_is_read ? IW'(r_s1_addr) : (r_s1_row_base + IW'(r_s1_col));

endmodule

### hdl/r2bpp_fifo.sv
// two-entry command queue between front and back
// depends on r2bpp_pkg
module r2bpp_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  r2bpp_pkg::t_cmd i_push_cmd,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output r2bpp_pkg::t_cmd o_pop_cmd
);

    r2bpp_pkg::t_cmd r_buf [2];
    logic            r_wr_ptr, r_rd_ptr;
    logic [1:0]      r_count;
    logic            w_push, w_pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_cmd    = r_buf[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) r_wr_ptr <= !r_wr_ptr;
            if (w_pop)  r_rd_ptr <= !r_rd_ptr;
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_buf[r_wr_ptr] <= i_push_cmd;
    end

endmodule

### hdl/r2bpp_back.sv
// back end: frame store with clearing pass, read-modify-write merge, result register
// depends on r2bpp_pkg
module r2bpp_back #(
    parameter int FRAME_WIDTH  = 160,
    parameter int FRAME_HEIGHT = 296
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    output logic            o_cmd_ready,
    input  r2bpp_pkg::t_cmd i_cmd,
    output logic            o_clearing,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [1:0]      o_color_code,
    output logic [7:0]      o_read_data,
    output logic            o_range_error
);

    localparam int ROW_BYTES   = (FRAME_WIDTH + 3) / 4;
    localparam int STORE_BYTES = ROW_BYTES * FRAME_HEIGHT;
    localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_MERGE = 3'b100
    } t_back_state;

    t_back_state     r_state, n_state;
    logic [AW-1:0]   r_clr_addr;
    r2bpp_pkg::t_cmd r_cmd;
    logic [7:0]      r_mem [STORE_BYTES];
    logic [7:0]      r_rdata;
    logic            r_out_valid;
    logic [1:0]      r_out_code;
    logic [7:0]      r_out_data;
    logic            r_out_err;

    logic            w_pop, w_out_free, w_finish;
    logic            w_we;
    logic [AW-1:0]   w_waddr, w_raddr;
    logic [7:0]      w_wdata, w_merged;

    assign o_cmd_ready = (r_state == ST_IDLE);
    assign o_clearing  = (r_state == ST_CLEAR);
    assign w_pop       = i_cmd_valid && o_cmd_ready;
    assign w_out_free  = !r_out_valid || i_ready;
    assign w_finish    = (r_state == ST_MERGE) && w_out_free;

    // leftmost pixel sits in bits 7..6
    always_comb begin
        w_merged = r_rdata;
        w_merged[{~r_cmd.lane, 1'b1} -: 2] = r_cmd.code;
    end

    always_comb begin
        w_raddr = (r_state == ST_IDLE) ? i_cmd.idx[AW-1:0] : r_cmd.idx[AW-1:0];
        if (r_state == ST_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr_addr;
            w_wdata = r2bpp_pkg::CLEAR_BYTE;
        end else begin
            w_we    = w_finish && !r_cmd.is_read && !r_cmd.err;
            w_waddr = r_cmd.idx[AW-1:0];
            w_wdata = w_merged;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rdata <= r_mem[w_raddr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == AW'(STORE_BYTES - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (w_pop) n_state = ST_MERGE;
            end
            ST_MERGE: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr_addr <= r_clr_addr + AW'(1);
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) r_cmd <= i_cmd;
        if (w_finish) begin
            r_out_code <= r_cmd.is_read ? r2bpp_pkg::CODE_BLACK : r_cmd.code;
            r_out_data <= (r_cmd.is_read && !r_cmd.err) ? r_rdata : 8'd0;
            r_out_err  <= r_cmd.err;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_color_code  = r_out_code;
    assign o_read_data   = r_out_data;
    assign o_range_error = r_out_err;

endmodule

### hdl/rgb565_to_four_color_2bpp_packer.sv
// top level of the rgb565 four-color 2bpp packer: config registers, front, queue, back
// depends on r2bpp_pkg, r2bpp_front, r2bpp_fifo, r2bpp_back
//
// channel   direction  handshake            payload
// --------  ---------  -------------------  ---------------------------------------------
// item in   input      i_valid / o_ready    i_opcode, i_pixel, i_x_coord, i_y_coord,
//                                           i_read_address
// result    output     o_valid / i_ready    o_color_code, o_read_data, o_range_error
// config    apb        psel/penable/pready  paddr, pwrite, pwdata, prdata
//
// per item the back end reads a byte, then merges and writes it, and takes no new item
// until that write; the front takes an item a cycle into a 2-entry queue while it has room
// an item passes the front stage register, the queue, the back end merge state and the
// result register; after reset the store is swept to 0x55, one byte a cycle, over all
// ceil(FRAME_WIDTH/4)*FRAME_HEIGHT bytes (11840 by default); o_ready is low until it ends
// a stalled result sits in the output register while the front and queue keep filling
module rgb565_to_four_color_2bpp_packer #(
    parameter int FRAME_WIDTH  = 160,
    parameter int FRAME_HEIGHT = 296
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_opcode,
    input  logic [15:0] i_pixel,
    input  logic [9:0]  i_x_coord,
    input  logic [9:0]  i_y_coord,
    input  logic [13:0] i_read_address,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_color_code,
    output logic [7:0]  o_read_data,
    output logic        o_range_error,
    // apb config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [r2bpp_pkg::CFG_W-1:0] r_spread_thr;
    logic [r2bpp_pkg::CFG_W-1:0] r_luma_thr;
    logic                        w_cfg_write;

    logic            w_cmd_valid, w_cmd_ready;
    r2bpp_pkg::t_cmd w_cmd;
    logic            w_q_valid, w_q_ready;
    r2bpp_pkg::t_cmd w_q_cmd;
    logic            w_clearing;

    // registers are word aligned, paddr[2] picks the register
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spread_thr <= r2bpp_pkg::SPREAD_RESET;
            r_luma_thr   <= r2bpp_pkg::LUMA_RESET;
        end else if (w_cfg_write) begin
            case (paddr[2])
                r2bpp_pkg::REG_SPREAD: r_spread_thr <= pwdata[7:0];
                r2bpp_pkg::REG_LUMA:   r_luma_thr   <= pwdata[7:0];
                default:               r_spread_thr <= r_spread_thr;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            r2bpp_pkg::REG_SPREAD: prdata = {24'd0, r_spread_thr};
            r2bpp_pkg::REG_LUMA:   prdata = {24'd0, r_luma_thr};
            default:               prdata = 32'd0;
        endcase
    end

    // classify: color mapping and range checks, one stage of products
    r2bpp_front #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_opcode       (i_opcode),
        .i_pixel        (i_pixel),
        .i_x_coord      (i_x_coord),
        .i_y_coord      (i_y_coord),
        .i_read_address (i_read_address),
        .i_spread_thr   (r_spread_thr),
        .i_luma_thr     (r_luma_thr),
        .i_hold         (w_clearing),
        .o_cmd_valid    (w_cmd_valid),
        .o_cmd          (w_cmd),
        .i_cmd_ready    (w_cmd_ready)
    );

    // decouples classification from the store access
    r2bpp_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_cmd_valid),
        .o_push_ready (w_cmd_ready),
        .i_push_cmd   (w_cmd),
        .o_pop_valid  (w_q_valid),
        .i_pop_ready  (w_q_ready),
        .o_pop_cmd    (w_q_cmd)
    );

    // store access; write finishes before the next read is issued, so no forwarding
    r2bpp_back #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (w_q_valid),
        .o_cmd_ready   (w_q_ready),
        .i_cmd         (w_q_cmd),
        .o_clearing    (w_clearing),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_color_code  (o_color_code),
        .o_read_data   (o_read_data),
        .o_range_error (o_range_error)
    );

endmodule

### hdl/r2bpp_checker.sv
// port-level checker for the packer, attached to the top level by bind
// depends on rgb565_to_four_color_2bpp_packer port names only
module r2bpp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_color_code,
    input logic [7:0]  o_read_data,
    input logic        o_range_error,
    input logic        psel,
    input logic        penable,
    input logic        pready
);

    logic [3:0] r_pending;
    logic       w_in_acc, w_out_acc;

    assign w_in_acc  = i_valid && o_ready;
    assign w_out_acc = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 4'd0;
        end else if (w_in_acc && !w_out_acc) begin
            r_pending <= r_pending + 4'd1;
        end else if (w_out_acc && !w_in_acc) begin
            r_pending <= r_pending - 4'd1;
        end
    end

    // no result without an item still owed one
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_pending != 4'd0))
        else $error("result shown with no item outstanding");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_color_code)
                                   && $stable(o_read_data) && $stable(o_range_error)))
        else $error("stalled result changed");

    // read bytes come with a zero code and no error
    a_read_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_read_data != 8'd0)) |-> ((o_color_code == 2'd0) && !o_range_error))
        else $error("read data on a write or failed read");

    // store sweep starts right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_ready))
        else $error("item taken or result shown during store sweep");

    a_apb_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable) |-> pready)
        else $error("apb access not completed");

endmodule

bind rgb565_to_four_color_2bpp_packer r2bpp_checker u_checker (.*);

### bench/rgb565_to_four_color_2bpp_packer_tb.sv
`timescale 1ns / 1ps
// self-checking bench for rgb565_to_four_color_2bpp_packer: directed and random pixel writes
// and byte reads, checked against a local color mapper and frame store copy
// depends on r2bpp_pkg and the packer rtl
module rgb565_to_four_color_2bpp_packer_tb;

    localparam int FRAME_W     = 160;
    localparam int FRAME_H     = 296;
    localparam int ROW_BYTES   = (FRAME_W + 3) / 4;
    localparam int STORE_BYTES = ROW_BYTES * FRAME_H;
    // the limit allows for the clearing sweep over all STORE_BYTES bytes and then every item
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 150;

    // register byte addresses, one register every 4 bytes
    localparam logic [2:0] ADDR_SPREAD = {r2bpp_pkg::REG_SPREAD, 2'b00};
    localparam logic [2:0] ADDR_LUMA   = {r2bpp_pkg::REG_LUMA, 2'b00};

    typedef struct {
        logic        op;
        logic [15:0] px;
        logic [9:0]  x;
        logic [9:0]  y;
        logic [13:0] addr;
    } t_pix_item;

    typedef struct {
        logic [1:0] code;
        logic [7:0] data;
        logic       err;
    } t_packer_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_opcode = 1'b0;
    logic [15:0] i_pixel = '0;
    logic [9:0]  i_x_coord = '0;
    logic [9:0]  i_y_coord = '0;
    logic [13:0] i_read_address = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_color_code;
    logic [7:0]  o_read_data;
    logic        o_range_error;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // local copy of the block's state and registers
    logic [7:0] frame_copy [STORE_BYTES];
    logic [7:0] spread_thr;
    logic [7:0] luma_thr;

    t_pix_item      pending_items[$];
    t_packer_result expected_results[$];

    int accepted_count = 0;
    int result_count   = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    rgb565_to_four_color_2bpp_packer #(
        .FRAME_WIDTH (FRAME_W),
        .FRAME_HEIGHT(FRAME_H)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_opcode      (i_opcode),
        .i_pixel       (i_pixel),
        .i_x_coord     (i_x_coord),
        .i_y_coord     (i_y_coord),
        .i_read_address(i_read_address),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_color_code  (o_color_code),
        .o_read_data   (o_read_data),
        .o_range_error (o_range_error),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned r25_k(input logic [9:0] k);
        return int'(k);
    endfunction

    // map one rgb565 pixel to its four-color code under the current registers
    function automatic logic [1:0] classify_color(input logic [15:0] px);
        int unsigned r, g, b, hi, lo, luma, dk, dw, dy, dr, best;
        logic [1:0] code;
        // widen each channel by repeating its top bits
        r = {px[15:11], px[15:13]};
        g = {px[10:5], px[10:9]};
        b = {px[4:0], px[4:2]};
        hi = r;
        lo = r;
        if (g > hi) hi = g;
        if (b > hi) hi = b;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        // achromatic: luma picks black or white
        if (hi - lo < spread_thr) begin
            luma = (r25_k(r2bpp_pkg::LUMA_KR) * r + r25_k(r2bpp_pkg::LUMA_KG) * g
                    + r25_k(r2bpp_pkg::LUMA_KB) * b) / r25_k(r2bpp_pkg::LUMA_DIV);
            return (luma < luma_thr) ? r2bpp_pkg::CODE_BLACK : r2bpp_pkg::CODE_WHITE;
        end
        dk = r * r + g * g + b * b;
        dw = (255 - r) * (255 - r) + (255 - g) * (255 - g) + (255 - b) * (255 - b);
        dy = (255 - r) * (255 - r) + (255 - g) * (255 - g) + b * b;
        dr = (255 - r) * (255 - r) + g * g + b * b;
        // strict compares keep the earlier color on a tie
        code = r2bpp_pkg::CODE_BLACK;
        best = dk;
        if (dw < best) begin
            best = dw;
            code = r2bpp_pkg::CODE_WHITE;
        end
        if (dy < best) begin
            best = dy;
            code = r2bpp_pkg::CODE_YELLOW;
        end
        if (dr < best) code = r2bpp_pkg::CODE_RED;
        return code;
    endfunction

    // expected result of one accepted item, with the store merge for writes
    function automatic t_packer_result pack_pixel(input t_pix_item it);
        t_packer_result res;
        int unsigned idx, sh;
        res.code = '0;
        res.data = '0;
        res.err  = 1'b0;
        if (it.op == r2bpp_pkg::OP_WRITE) begin
            res.code = classify_color(it.px);
            if (it.x >= FRAME_W || it.y >= FRAME_H) begin
                res.err = 1'b1;
            end else begin
                idx = it.y * ROW_BYTES + it.x / 4;
                sh  = 6 - 2 * (it.x % 4);
                frame_copy[idx][sh +: 2] = res.code;
            end
        end else begin
            if (it.addr < STORE_BYTES) res.data = frame_copy[it.addr];
            else res.err = 1'b1;
        end
        return res;
    endfunction

    function automatic logic [15:0] rand_pixel();
        logic [4:0] v;
        logic [15:0] palette [7];
        palette = '{16'h0000, 16'hFFFF, 16'hF800, 16'hFFE0, 16'h07E0, 16'hF81F, 16'h07FF};
        case ($urandom_range(0, 3))
            0, 1: return 16'($urandom);
            2: begin
                // near-gray: channels track each other with a little jitter
                v = 5'($urandom);
                return {v, v, 1'($urandom), v ^ 5'($urandom_range(0, 3))};
            end
            default: return palette[$urandom_range(0, 6)];
        endcase
    endfunction

    task automatic push_item(input logic op, input logic [15:0] px, input int x, input int y,
                             input int addr);
        t_pix_item it;
        it.op   = op;
        it.px   = px;
        it.x    = 10'(x);
        it.y    = 10'(y);
        it.addr = 14'(addr);
        pending_items.push_back(it);
    endtask

    task automatic queue_random_items(input int count);
        t_pix_item it;
        int sel, row, col, k;
        for (int n = 0; n < count; n++) begin
            it.op   = r2bpp_pkg::OP_WRITE;
            it.px   = rand_pixel();
            it.x    = 10'($urandom);
            it.y    = 10'($urandom);
            it.addr = 14'($urandom);
            sel = $urandom_range(0, 99);
            if (sel < 30) begin
                // writes into a small hot corner so reads hit fresh data
                it.x = 10'($urandom_range(0, 15));
                it.y = 10'($urandom_range(0, 3));
            end else if (sel < 48) begin
                it.op   = r2bpp_pkg::OP_READ;
                it.addr = 14'($urandom_range(0, 3) * ROW_BYTES + $urandom_range(0, 3));
            end else if (sel < 56) begin
                // four pixels of one byte back to back, then its read
                row = $urandom_range(0, FRAME_H - 1);
                col = 4 * $urandom_range(0, ROW_BYTES - 1);
                for (k = 0; k < 4; k++) push_item(r2bpp_pkg::OP_WRITE, rand_pixel(), col + k,
                                                  row, $urandom_range(0, 16383));
                it.op   = r2bpp_pkg::OP_READ;
                it.addr = 14'(row * ROW_BYTES + col / 4);
            end else if (sel < 72) begin
                it.x = 10'($urandom_range(0, FRAME_W - 1));
                it.y = 10'($urandom_range(0, FRAME_H - 1));
            end else if (sel < 84) begin
                it.op   = r2bpp_pkg::OP_READ;
                it.addr = 14'($urandom_range(0, STORE_BYTES - 1));
            end else if (sel < 92) begin
                // full field range, mostly out of frame
            end else begin
                it.op = r2bpp_pkg::OP_READ;
            end
            pending_items.push_back(it);
        end
    endtask

    // register write, setup then access; the local copy follows at the write edge
    task automatic apb_write(input logic [2:0] addr, input logic [7:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {24'h0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == ADDR_SPREAD) spread_thr = value;
        else if (addr == ADDR_LUMA) luma_thr = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || i_valid || expected_results.size() != 0);
    endtask

    // item driver: predicts each accepted item, then offers the next one or idles
    always @(posedge i_clk) begin
        t_pix_item it;
        bit        quiet;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                it.op   = i_opcode;
                it.px   = i_pixel;
                it.x    = i_x_coord;
                it.y    = i_y_coord;
                it.addr = i_read_address;
                expected_results.push_back(pack_pixel(it));
                accepted_count++;
            end
            if (!i_valid || o_ready) begin
                // long stretch with no gaps in the middle of the run
                quiet = (accepted_count >= 300 && accepted_count < 500);
                if (pending_items.size() != 0 && (quiet || $urandom_range(0, 99) >= 24)) begin
                    it = pending_items.pop_front();
                    i_valid        <= 1'b1;
                    i_opcode       <= it.op;
                    i_pixel        <= it.px;
                    i_x_coord      <= it.x;
                    i_y_coord      <= it.y;
                    i_read_address <= it.addr;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: compares against the oldest expectation, stalls at random
    always @(posedge i_clk) begin
        t_packer_result want;
        bit             quiet;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                result_count++;
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: code %0d data %h err %0d",
                                 o_color_code, o_read_data, o_range_error);
                end else begin
                    want = expected_results.pop_front();
                    if (o_color_code !== want.code || o_read_data !== want.data ||
                        o_range_error !== want.err) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $write("result %0d: expected code %0d data %h err %0d",
                                   result_count, want.code, want.data, want.err);
                            $display(", got code %0d data %h err %0d",
                                     o_color_code, o_read_data, o_range_error);
                        end
                    end
                end
            end
            quiet = (result_count >= 300 && result_count < 500);
            i_ready <= quiet || ($urandom_range(0, 99) >= 24);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        logic [7:0] spread_set [5];
        logic [7:0] luma_set [5];
        for (int i = 0; i < STORE_BYTES; i++) frame_copy[i] = r2bpp_pkg::CLEAR_BYTE;
        spread_thr = r2bpp_pkg::SPREAD_RESET;
        luma_thr   = r2bpp_pkg::LUMA_RESET;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at the reset register values
        push_item(r2bpp_pkg::OP_WRITE, 16'h0000, 0, 0, 16383);
        push_item(r2bpp_pkg::OP_READ, 16'hFFFF, 1023, 1023, 0);
        push_item(r2bpp_pkg::OP_WRITE, 16'hFFFF, FRAME_W - 1, FRAME_H - 1, 0);
        push_item(r2bpp_pkg::OP_READ, 16'h0000, 0, 0, STORE_BYTES - 1);
        push_item(r2bpp_pkg::OP_READ, 16'h0000, 0, 0, STORE_BYTES);
        push_item(r2bpp_pkg::OP_READ, 16'h0000, 0, 0, 16383);
        push_item(r2bpp_pkg::OP_WRITE, 16'hF800, FRAME_W, 0, 0);
        push_item(r2bpp_pkg::OP_WRITE, 16'hFFE0, 0, FRAME_H, 0);
        push_item(r2bpp_pkg::OP_WRITE, 16'h07E0, 1023, 1023, 0);
        // pure green ties black with yellow, magenta ties white with red
        push_item(r2bpp_pkg::OP_WRITE, 16'h07E0, 4, 1, 0);
        push_item(r2bpp_pkg::OP_WRITE, 16'hF81F, 5, 1, 0);
        push_item(r2bpp_pkg::OP_WRITE, 16'hF800, 6, 1, 0);
        push_item(r2bpp_pkg::OP_WRITE, 16'hFFE0, 7, 1, 0);
        push_item(r2bpp_pkg::OP_READ, 16'h0000, 0, 0, ROW_BYTES + 1);
        // dark and light gray, then cyan and blue
        push_item(r2bpp_pkg::OP_WRITE, 16'h8410, 1, 0, 0);
        push_item(r2bpp_pkg::OP_WRITE, 16'hC618, 2, 0, 0);
        push_item(r2bpp_pkg::OP_WRITE, 16'h07FF, 3, 0, 0);
        push_item(r2bpp_pkg::OP_READ, 16'h0000, 0, 0, 0);
        push_item(r2bpp_pkg::OP_WRITE, 16'h001F, 3, 0, 0);
        push_item(r2bpp_pkg::OP_WRITE, 16'h001F, 3, 0, 0);
        push_item(r2bpp_pkg::OP_READ, 16'h0000, 0, 0, 0);
        push_item(r2bpp_pkg::OP_READ, 16'h0000, 0, 0, STORE_BYTES - 1);
        wait_drained();

        // random phases at register extremes, one random setting and the reset values
        spread_set = '{8'd0, 8'd255, 8'd255, 8'($urandom), r2bpp_pkg::SPREAD_RESET};
        luma_set   = '{8'd255, 8'd0, 8'd255, 8'($urandom), r2bpp_pkg::LUMA_RESET};
        for (int p = 0; p < 5; p++) begin
            apb_write(ADDR_SPREAD, spread_set[p]);
            apb_write(ADDR_LUMA, luma_set[p]);
            queue_random_items(PHASE_ITEMS);
            wait_drained();
        end

        // let any stray result show up before the verdict
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
